>>> rtl/core/humidity_pressure_temp_compensation_assert.svh
// Assertion macros for the sensor compensation block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef HUMIDITY_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
`define HUMIDITY_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HPTC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hptc same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define HPTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hptc next-cycle check failed");

// Condition that must hold in the cycle after reset was high.
`define HPTC_ASSERT_AFTER_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) $past(rst) |-> (cons)) \
    else $error("hptc reset check failed");

`endif

>>> rtl/core/hptc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hptc_pkg
// Types, register indexes and helpers shared by the compensation pipeline.
// ----------------------------------------------------------------------------
package hptc_pkg;

  localparam int DIV_STAGES = 32;

  localparam logic [2:0] REG_TEMP_CAL       = 3'd0;
  localparam logic [2:0] REG_PRESS_CAL_LOW  = 3'd1;
  localparam logic [2:0] REG_PRESS_CAL_HIGH = 3'd2;
  localparam logic [2:0] REG_PRESS_CAL_LAST = 3'd3;
  localparam logic [2:0] REG_HUM_CAL_LOW    = 3'd4;
  localparam logic [2:0] REG_HUM_CAL_HIGH   = 3'd5;

  localparam logic [31:0] HUM_MAX = 32'd419430400;

  // Calibration words, extended to 32 bits
  typedef struct packed {
    logic [31:0] t1, t2, t3;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
  } cal_t;

  // One step of the restoring divider
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] num;
    logic [31:0] quo;
    logic [31:0] div;
  } div_st_t;

  // Item fields that ride alongside the divider
  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] hx;
    logic        bad;
    logic        dbl;
  } side_t;

  function automatic logic [31:0] sra(input logic [31:0] x, input int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic div_st_t div_step(input div_st_t s);
    logic [32:0] t;
    div_st_t     o;
    t     = {s.rem, s.num[31]};
    o     = s;
    o.num = {s.num[30:0], 1'b0};
    if (t >= {1'b0, s.div}) begin
      o.rem = 32'(t - {1'b0, s.div});
      o.quo = {s.quo[30:0], 1'b1};
    end else begin
      o.rem = t[31:0];
      o.quo = {s.quo[30:0], 1'b0};
    end
    return o;
  endfunction

endpackage

>>> rtl/core/humidity_pressure_temp_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_pressure_temp_compensation
// Raw ADC sample set in, compensated temperature, pressure and humidity out.
// ----------------------------------------------------------------------------
//  channel   direction  carries
//  s_axis    in         raw temperature, pressure, humidity sample set
//  m_axis    out        temperature, pressure, humidity, pressure-invalid flag
//  cfg       in         calibration register writes (index, data)
//
//  One item per cycle while the output is not stalled; 11 front stages,
//  32 divider stages and 4 tail stages, the divider giving a bit per stage.
//  rst clears all valid bits and the calibration registers to zero.
//  A waiting result stalls the whole pipeline in place; s_axis_tready
//  stays high while the output is empty or being taken.
// ----------------------------------------------------------------------------
module humidity_pressure_temp_compensation import hptc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // raw_temperature, raw_pressure, raw_humidity
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // temperature_centi, pressure_pa, humidity_q10, pad
  output logic [0:0]  m_axis_tuser,   // pressure_invalid
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [47:0] temp_calibration;
  logic [63:0] press_calibration_low;
  logic [63:0] press_calibration_high;
  logic [15:0] press_calibration_last;
  logic [39:0] hum_calibration_low;
  logic [31:0] hum_calibration_high;

  cal_t        cal;
  logic        adv;
  logic        f_valid, d_valid;
  div_st_t     f_div;
  side_t       f_side, d_side;
  logic [31:0] d_quo;
  logic [31:0] temperature_centi, pressure_pa;
  logic [16:0] humidity_q10;
  logic        pressure_invalid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calibration       <= '0;
      press_calibration_low  <= '0;
      press_calibration_high <= '0;
      press_calibration_last <= '0;
      hum_calibration_low    <= '0;
      hum_calibration_high   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TEMP_CAL:       temp_calibration       <= cfg_data[47:0];
        REG_PRESS_CAL_LOW:  press_calibration_low  <= cfg_data;
        REG_PRESS_CAL_HIGH: press_calibration_high <= cfg_data;
        REG_PRESS_CAL_LAST: press_calibration_last <= cfg_data[15:0];
        REG_HUM_CAL_LOW:    hum_calibration_low    <= cfg_data[39:0];
        REG_HUM_CAL_HIGH:   hum_calibration_high   <= cfg_data[31:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign cal.t1 = {16'd0, temp_calibration[15:0]};
  assign cal.t2 = sx16(temp_calibration[31:16]);
  assign cal.t3 = sx16(temp_calibration[47:32]);
  assign cal.p1 = {16'd0, press_calibration_low[15:0]};
  assign cal.p2 = sx16(press_calibration_low[31:16]);
  assign cal.p3 = sx16(press_calibration_low[47:32]);
  assign cal.p4 = sx16(press_calibration_low[63:48]);
  assign cal.p5 = sx16(press_calibration_high[15:0]);
  assign cal.p6 = sx16(press_calibration_high[31:16]);
  assign cal.p7 = sx16(press_calibration_high[47:32]);
  assign cal.p8 = sx16(press_calibration_high[63:48]);
  assign cal.p9 = sx16(press_calibration_last);
  assign cal.h1 = {24'd0, hum_calibration_low[7:0]};
  assign cal.h2 = sx16(hum_calibration_low[23:8]);
  assign cal.h3 = {24'd0, hum_calibration_low[31:24]};
  assign cal.h6 = sx8(hum_calibration_low[39:32]);
  assign cal.h4 = sx16(hum_calibration_high[15:0]);
  assign cal.h5 = sx16(hum_calibration_high[31:16]);

  // advance the whole pipeline unless a result is waiting
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  hptc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .in_valid        (s_axis_tvalid),
    .raw_temperature (s_axis_tdata[19:0]),
    .raw_pressure    (s_axis_tdata[39:20]),
    .raw_humidity    (s_axis_tdata[55:40]),
    .cal             (cal),
    .out_valid       (f_valid),
    .out_div         (f_div),
    .out_side        (f_side)
  );

  hptc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (f_valid),
    .in_div    (f_div),
    .in_side   (f_side),
    .out_valid (d_valid),
    .out_quo   (d_quo),
    .out_side  (d_side)
  );

  hptc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .adv               (adv),
    .in_valid          (d_valid),
    .in_quo            (d_quo),
    .in_side           (d_side),
    .cal               (cal),
    .out_valid         (m_axis_tvalid),
    .temperature_centi (temperature_centi),
    .pressure_pa       (pressure_pa),
    .humidity_q10      (humidity_q10),
    .pressure_invalid  (pressure_invalid)
  );

  assign m_axis_tdata    = {7'd0, humidity_q10, pressure_pa, temperature_centi};
  assign m_axis_tuser[0] = pressure_invalid;

`include "humidity_pressure_temp_compensation_assert.svh"

  `HPTC_ASSERT_NOW(a_invalid_zero, m_axis_tvalid && pressure_invalid, pressure_pa == 32'd0)
  `HPTC_ASSERT_NOW(a_hum_range, m_axis_tvalid, humidity_q10 <= 17'd102400)
  `HPTC_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `HPTC_ASSERT_AFTER_RST(a_reset_empty, !m_axis_tvalid)

endmodule

>>> rtl/core/hptc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hptc_front
// Eleven-stage datapath: fine temperature, pressure terms up to the divider
// operands, and humidity up to its main product.
// ----------------------------------------------------------------------------
module hptc_front import hptc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_valid,
  input  logic [19:0] raw_temperature,
  input  logic [19:0] raw_pressure,
  input  logic [15:0] raw_humidity,
  input  cal_t        cal,
  output logic        out_valid,
  output div_st_t     out_div,
  output side_t       out_side
);

  logic [10:0] vld;

  logic [31:0] r1_ta0, r1_d;
  logic [19:0] r1_p, r2_p, r3_p, r4_p, r5_p, r6_p, r7_p, r8_p;
  logic [15:0] r1_h, r2_h, r3_h, r4_h, r5_h, r6_h;
  logic [31:0] r2_ta, r2_dd;
  logic [31:0] r3_a, r3_b;
  logic [31:0] r4_fine;
  logic [31:0] r5_temp, r5_pa, r5_x;
  logic [31:0] r6_temp, r6_qq, r6_ap5, r6_p2a, r6_hx, r6_xh6, r6_xh3;
  logic [31:0] r7_temp, r7_b, r7_c, r7_ha, r7_hb, r7_ap5, r7_p2a;
  logic [31:0] r8_temp, r8_bs, r8_av, r8_ha, r8_hb;
  logic [31:0] r9_temp, r9_a, r9_hb, r9_pr, r9_ha;
  logic [31:0] r10_temp, r10_div, r10_pm, r10_hb, r10_ha;
  logic [31:0] r11_temp, r11_num, r11_div, r11_hx;
  logic        r11_bad, r11_dbl;
  logic [31:0] q5;

  assign q5 = sra(r5_pa, 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[9:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // temperature
      r1_ta0 <= ({12'd0, raw_temperature} >> 3) - (cal.t1 << 1);
      r1_d   <= ({12'd0, raw_temperature} >> 4) - cal.t1;
      r1_p   <= raw_pressure;
      r1_h   <= raw_humidity;

      r2_ta  <= r1_ta0 * cal.t2;
      r2_dd  <= r1_d * r1_d;
      r2_p   <= r1_p;
      r2_h   <= r1_h;

      r3_a   <= sra(r2_ta, 11);
      r3_b   <= sra(r2_dd, 12) * cal.t3;
      r3_p   <= r2_p;
      r3_h   <= r2_h;

      r4_fine <= r3_a + sra(r3_b, 14);
      r4_p    <= r3_p;
      r4_h    <= r3_h;

      r5_temp <= sra(r4_fine * 32'd5 + 32'd128, 8);
      r5_pa   <= sra(r4_fine, 1) - 32'd64000;
      r5_x    <= r4_fine - 32'd76800;
      r5_p    <= r4_p;
      r5_h    <= r4_h;

      // pressure and humidity products
      r6_temp <= r5_temp;
      r6_qq   <= q5 * q5;
      r6_ap5  <= r5_pa * cal.p5;
      r6_p2a  <= cal.p2 * r5_pa;
      r6_hx   <= cal.h5 * r5_x;
      r6_xh6  <= r5_x * cal.h6;
      r6_xh3  <= r5_x * cal.h3;
      r6_p    <= r5_p;
      r6_h    <= r5_h;

      r7_temp <= r6_temp;
      r7_b    <= sra(r6_qq, 11) * cal.p6;
      r7_c    <= cal.p3 * sra(r6_qq, 13);
      r7_ha   <= ({16'd0, r6_h} << 14) - (cal.h4 << 20) - r6_hx + 32'd16384;
      r7_hb   <= sra(r6_xh6, 10) * (sra(r6_xh3, 11) + 32'd32768);
      r7_ap5  <= r6_ap5;
      r7_p2a  <= r6_p2a;
      r7_p    <= r6_p;

      r8_temp <= r7_temp;
      r8_bs   <= sra(r7_b + (r7_ap5 << 1), 2) + (cal.p4 << 16);
      r8_av   <= sra(sra(r7_c, 3) + sra(r7_p2a, 1), 18);
      r8_ha   <= sra(r7_ha, 15);
      r8_hb   <= sra(r7_hb, 10) + 32'd2097152;
      r8_p    <= r7_p;

      r9_temp <= r8_temp;
      r9_a    <= (32'd32768 + r8_av) * cal.p1;
      r9_hb   <= r8_hb * cal.h2;
      r9_pr   <= (32'd1048576 - {12'd0, r8_p}) - sra(r8_bs, 12);
      r9_ha   <= r8_ha;

      r10_temp <= r9_temp;
      r10_div  <= sra(r9_a, 15);
      r10_pm   <= r9_pr * 32'd3125;
      r10_hb   <= sra(r9_hb + 32'd8192, 14);
      r10_ha   <= r9_ha;

      // divider operands; a small dividend is doubled ahead, a large one by doubling the quotient after
      r11_temp <= r10_temp;
      r11_num  <= r10_pm[31] ? r10_pm : (r10_pm << 1);
      r11_dbl  <= r10_pm[31];
      r11_div  <= r10_div;
      r11_bad  <= (r10_div == 32'd0);
      r11_hx   <= r10_ha * r10_hb;
    end
  end

  assign out_valid     = vld[10];
  assign out_div.rem   = 32'd0;
  assign out_div.num   = r11_num;
  assign out_div.quo   = 32'd0;
  assign out_div.div   = r11_div;
  assign out_side.temp = r11_temp;
  assign out_side.hx   = r11_hx;
  assign out_side.bad  = r11_bad;
  assign out_side.dbl  = r11_dbl;

endmodule

>>> rtl/core/hptc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hptc_div
// Pipelined unsigned 32 by 32 restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module hptc_div import hptc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    adv,
  input  logic    in_valid,
  input  div_st_t in_div,
  input  side_t   in_side,
  output logic    out_valid,
  output logic [31:0] out_quo,
  output side_t   out_side
);

  logic [DIV_STAGES-1:0] vld;
  div_st_t               st [DIV_STAGES];
  side_t                 sd [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DIV_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        if (k == 0) begin
          st[k] <= div_step(in_div);
          sd[k] <= in_side;
        end else begin
          st[k] <= div_step(st[k-1]);
          sd[k] <= sd[k-1];
        end
      end
    end
  end

  assign out_valid = vld[DIV_STAGES-1];
  assign out_quo   = st[DIV_STAGES-1].quo;
  assign out_side  = sd[DIV_STAGES-1];

endmodule

>>> rtl/core/hptc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hptc_back
// Four-stage tail: pressure correction after the divide, humidity finish
// and clamp. The last stage is the output register.
// ----------------------------------------------------------------------------
module hptc_back import hptc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_valid,
  input  logic [31:0] in_quo,
  input  side_t       in_side,
  input  cal_t        cal,
  output logic        out_valid,
  output logic [31:0] temperature_centi,
  output logic [31:0] pressure_pa,
  output logic [16:0] humidity_q10,
  output logic        pressure_invalid
);

  logic [3:0]  vld;
  logic [31:0] b1_temp, b1_pres, b1_hq, b1_hx;
  logic        b1_bad;
  logic [31:0] b2_temp, b2_pres, b2_xx, b2_pb, b2_hqq, b2_hx;
  logic        b2_bad;
  logic [31:0] b3_temp, b3_pres, b3_pa9, b3_pb, b3_ht, b3_hx;
  logic        b3_bad;
  logic [31:0] x2, hv, hc;

  assign x2 = b1_pres >> 3;
  assign hv = b3_hx - sra(b3_ht, 4);

  always_comb begin
    if (hv[31]) begin
      hc = 32'd0;
    end else if (hv > HUM_MAX) begin
      hc = HUM_MAX;
    end else begin
      hc = hv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_temp <= in_side.temp;
      b1_pres <= in_side.dbl ? (in_quo << 1) : in_quo;
      b1_hq   <= sra(in_side.hx, 15);
      b1_hx   <= in_side.hx;
      b1_bad  <= in_side.bad;

      b2_temp <= b1_temp;
      b2_pres <= b1_pres;
      b2_xx   <= x2 * x2;
      b2_pb   <= (b1_pres >> 2) * cal.p8;
      b2_hqq  <= b1_hq * b1_hq;
      b2_hx   <= b1_hx;
      b2_bad  <= b1_bad;

      b3_temp <= b2_temp;
      b3_pres <= b2_pres;
      b3_pa9  <= cal.p9 * (b2_xx >> 13);
      b3_pb   <= b2_pb;
      b3_ht   <= sra(b2_hqq, 7) * cal.h1;
      b3_hx   <= b2_hx;
      b3_bad  <= b2_bad;

      temperature_centi <= b3_temp;
      // zero divisor forces pressure to zero
      pressure_pa       <= b3_bad ? 32'd0
                         : b3_pres + sra(sra(b3_pa9, 12) + sra(b3_pb, 13) + cal.p7, 4);
      pressure_invalid  <= b3_bad;
      humidity_q10      <= hc[28:12];
    end
  end

  assign out_valid = vld[3];

endmodule
